>>> hdl/mscg_pkg.sv
`default_nettype none

package mscg_pkg;

    // field and register widths
    localparam int IDX_W     = 16;
    localparam int TOTAL_W   = 16;
    localparam int STOP_W    = 3;
    localparam int CH_W      = 8;
    localparam int COLOR_W   = 3 * CH_W;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = COLOR_W;

    localparam int NUM_COLORS = 6;
    localparam int COLOR_SEL_W = $clog2(NUM_COLORS);

    localparam logic [TOTAL_W-1:0] DEFAULT_STEPS = TOTAL_W'(100);
    localparam logic [IDX_W-1:0]   IDX_MAX       = '1;

    // register map
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_COUNT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_STOP_0 = 3'd2;

    localparam logic [STOP_W-1:0] STOP_COUNT_RESET = 3'd6;

    localparam logic [NUM_COLORS-1:0][COLOR_W-1:0] COLOR_RESET = {
        24'h216AAC, 24'h67A9CF, 24'hD1E5F0, 24'hFDDBC7, 24'hEF8A62, 24'hB2182B
    };

    typedef struct packed {
        logic [TOTAL_W-1:0]                 total_count;
        logic [STOP_W-1:0]                  stop_count;
        logic [NUM_COLORS-1:0][COLOR_W-1:0] color_stop;
    } cfg_t;

    typedef enum logic [1:0] {
        CH_RED,
        CH_GREEN,
        CH_BLUE
    } chan_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIVIDE,
        ST_FETCH_LO,
        ST_FETCH_HI,
        ST_BLEND,
        ST_DELIVER
    } state_t;

    typedef struct packed {
        logic  setup;
        logic  div_step;
        logic  fetch_lo;
        logic  fetch_hi;
        logic  blend;
        chan_t ch_sel;
        logic  load_out;
    } cmd_t;

    typedef struct packed {
        logic over;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

>>> hdl/multi_stop_color_gradient.sv
// A request item runs through setup, the bit-serial divide, two stop fetches, the blend
//   and delivery; past the end of the ramp the divider is skipped.
// The bit-serial restoring divider makes one quotient bit per cycle; a new request is
//   taken only once the previous color has been loaded into the output register.
// Items with request low are taken while idle and give no result.
// Reset (aresetn, synchronous, active low) clears the request counter and loads defaults.
`default_nettype none

module multi_stop_color_gradient #(
    parameter int MAX_STOPS = 6,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // configuration write port
    input  wire logic                             cfg_wr_en,
    input  wire logic [mscg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [mscg_pkg::CFG_W-1:0]       cfg_wr_data,
    // request items
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic                             s_request,
    // color items
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [mscg_pkg::CH_W-1:0]             m_red,
    output logic [mscg_pkg::CH_W-1:0]             m_green,
    output logic [mscg_pkg::CH_W-1:0]             m_blue
);

    mscg_pkg::cfg_t    cfg;
    mscg_pkg::cmd_t    cmd;
    mscg_pkg::status_t status;

    // Register file: ramp length, stop count and the six stop colors.
    mscg_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    // Sequencer: setup, divide (skipped past the ramp end), fetch the two stops, blend three channels, deliver.
    mscg_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_request (s_request),
        .s_ready   (s_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath: position = index * (stops - 1) / d in fixed point, then a shared
    // multiplier interpolates one channel per cycle. The output register lets a
    // new request in while a finished color waits on m_ready.
    mscg_datapath #(
        .MAX_STOPS (MAX_STOPS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .cmd     (cmd),
        .status  (status),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_red   (m_red),
        .m_green (m_green),
        .m_blue  (m_blue)
    );

    // a real request makes the block busy on the next cycle
    a_busy_after_request: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_request) |=> !s_ready)
        else $error("block still ready after taking a request");

    // an item with request low produces no color
    a_no_result_on_idle_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !s_request && !m_valid) |=> !m_valid)
        else $error("color produced for an item without request");

    // a color only appears at the end of a busy sequence
    a_result_from_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("color appeared while the sequencer was idle");

endmodule

`default_nettype wire

>>> hdl/mscg_cfg_regs.sv
`default_nettype none

module mscg_cfg_regs (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [mscg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mscg_pkg::CFG_W-1:0]      cfg_wr_data,
    output mscg_pkg::cfg_t                       cfg
);

    mscg_pkg::cfg_t cfg_reg;
    mscg_pkg::cfg_t cfg_next;
    logic [mscg_pkg::CFG_IDX_W-1:0] color_sel;

    assign color_sel = cfg_index - mscg_pkg::REG_COLOR_STOP_0;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                mscg_pkg::REG_TOTAL_COUNT: begin
                    cfg_next.total_count = cfg_wr_data[mscg_pkg::TOTAL_W-1:0];
                end
                mscg_pkg::REG_STOP_COUNT: begin
                    cfg_next.stop_count = cfg_wr_data[mscg_pkg::STOP_W-1:0];
                end
                default: begin
                    // remaining indexes are the six color stops
                    cfg_next.color_stop[color_sel[mscg_pkg::COLOR_SEL_W-1:0]] =
                        cfg_wr_data[mscg_pkg::COLOR_W-1:0];
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.total_count <= '0;
            cfg_reg.stop_count  <= mscg_pkg::STOP_COUNT_RESET;
            cfg_reg.color_stop  <= mscg_pkg::COLOR_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> hdl/mscg_ctrl.sv
`default_nettype none

module mscg_ctrl #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    input  wire logic              s_request,
    output logic                   s_ready,
    input  wire mscg_pkg::status_t status,
    output mscg_pkg::cmd_t         cmd
);

    localparam int QW    = mscg_pkg::STOP_W + FRAC_BITS;
    localparam int CNT_W = $clog2(QW);

    mscg_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    mscg_pkg::chan_t  ch_reg, ch_next;
    logic             div_last;
    logic             blend_last;

    assign div_last   = (cnt_reg == CNT_W'(QW - 1));
    assign blend_last = (ch_reg == mscg_pkg::CH_BLUE);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mscg_pkg::ST_IDLE: begin
                if (s_valid && s_request) state_next = mscg_pkg::ST_SETUP;
            end
            mscg_pkg::ST_SETUP: begin
                // past the end the position is fixed, no division needed
                state_next = status.over ? mscg_pkg::ST_FETCH_LO : mscg_pkg::ST_DIVIDE;
            end
            mscg_pkg::ST_DIVIDE: begin
                if (div_last) state_next = mscg_pkg::ST_FETCH_LO;
            end
            mscg_pkg::ST_FETCH_LO: begin
                state_next = mscg_pkg::ST_FETCH_HI;
            end
            mscg_pkg::ST_FETCH_HI: begin
                state_next = mscg_pkg::ST_BLEND;
            end
            mscg_pkg::ST_BLEND: begin
                if (blend_last) state_next = mscg_pkg::ST_DELIVER;
            end
            mscg_pkg::ST_DELIVER: begin
                if (status.out_free) state_next = mscg_pkg::ST_IDLE;
            end
            default: state_next = mscg_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_ready      = 1'b0;
        cmd          = '0;
        cmd.ch_sel   = ch_reg;
        unique case (state_reg)
            mscg_pkg::ST_IDLE:     s_ready      = 1'b1;
            mscg_pkg::ST_SETUP:    cmd.setup    = 1'b1;
            mscg_pkg::ST_DIVIDE:   cmd.div_step = 1'b1;
            mscg_pkg::ST_FETCH_LO: cmd.fetch_lo = 1'b1;
            mscg_pkg::ST_FETCH_HI: cmd.fetch_hi = 1'b1;
            mscg_pkg::ST_BLEND:    cmd.blend    = 1'b1;
            mscg_pkg::ST_DELIVER:  cmd.load_out = status.out_free;
            default: ;
        endcase
    end

    // step and channel counters
    always_comb begin
        cnt_next = cnt_reg;
        ch_next  = ch_reg;
        if (state_reg == mscg_pkg::ST_SETUP) begin
            cnt_next = '0;
            ch_next  = mscg_pkg::CH_RED;
        end else if (state_reg == mscg_pkg::ST_DIVIDE) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (state_reg == mscg_pkg::ST_BLEND) begin
            case (ch_reg)
                mscg_pkg::CH_RED:   ch_next = mscg_pkg::CH_GREEN;
                mscg_pkg::CH_GREEN: ch_next = mscg_pkg::CH_BLUE;
                default:            ch_next = mscg_pkg::CH_RED;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mscg_pkg::ST_IDLE;
            cnt_reg   <= '0;
            ch_reg    <= mscg_pkg::CH_RED;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ch_reg    <= ch_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/mscg_datapath.sv
`default_nettype none

module mscg_datapath #(
    parameter int MAX_STOPS = 6,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire mscg_pkg::cfg_t              cfg,
    input  wire mscg_pkg::cmd_t              cmd,
    output mscg_pkg::status_t                status,
    input  wire logic                        m_ready,
    output logic                             m_valid,
    output logic [mscg_pkg::CH_W-1:0]        m_red,
    output logic [mscg_pkg::CH_W-1:0]        m_green,
    output logic [mscg_pkg::CH_W-1:0]        m_blue
);

    localparam int SW  = mscg_pkg::STOP_W;
    localparam int IW  = mscg_pkg::IDX_W;
    localparam int CW  = mscg_pkg::CH_W;
    localparam int QW  = SW + FRAC_BITS;
    localparam int MW  = IW + SW;
    localparam int PW  = CW + 1 + FRAC_BITS + 1;
    localparam logic [FRAC_BITS-1:0] CLAMP_FRAC = FRAC_BITS'((9 * (2 ** FRAC_BITS)) / 10);

    logic [IW-1:0]   idx_reg, idx_next;
    logic [IW-1:0]   rem_reg, rem_next;
    logic [QW-1:0]   sh_reg, sh_next;
    logic [QW-1:0]   quo_reg, quo_next;
    logic [mscg_pkg::COLOR_W-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [CW-1:0]   red_reg, red_next, green_reg, green_next, blue_reg, blue_next;
    logic [CW-1:0]   out_r_reg, out_r_next, out_g_reg, out_g_next, out_b_reg, out_b_next;
    logic            m_valid_reg, m_valid_next;

    logic [SW-1:0]   stops, stops_m1;
    logic [IW-1:0]   d;
    logic            over;
    logic [MW-1:0]   prod_m;
    logic [IW:0]     trial;
    logic            ge;
    logic [SW-1:0]   base, hi_sel, sel_idx;
    logic [FRAC_BITS-1:0] frac;
    logic [mscg_pkg::COLOR_W-1:0] sel_color;
    logic [CW-1:0]   lo_ch, hi_ch, mix_ch;
    logic signed [CW:0]        diff;
    logic signed [FRAC_BITS:0] frac_s;
    logic signed [PW-1:0]      prod_c, prod_sh;

    // stop count clamp and ramp length
    always_comb begin
        if (cfg.stop_count < SW'(2))
            stops = SW'(2);
        else if (cfg.stop_count > SW'(MAX_STOPS))
            stops = SW'(MAX_STOPS);
        else
            stops = cfg.stop_count;
        stops_m1 = stops - SW'(1);
        d = (cfg.total_count > mscg_pkg::TOTAL_W'(1)) ?
            (cfg.total_count - mscg_pkg::TOTAL_W'(1)) : mscg_pkg::DEFAULT_STEPS;
        over   = (idx_reg > d);
        prod_m = MW'(idx_reg) * MW'(stops_m1);
    end

    // restoring divider step; remainder stays below d
    assign trial = {rem_reg, sh_reg[QW-1]};
    assign ge    = (trial >= {1'b0, d});

    assign base   = quo_reg[QW-1:FRAC_BITS];
    assign frac   = quo_reg[FRAC_BITS-1:0];
    assign hi_sel = (base >= stops_m1) ? base : (base + SW'(1));
    assign sel_idx = cmd.fetch_hi ? hi_sel : base;
    assign sel_color = (sel_idx < SW'(mscg_pkg::NUM_COLORS)) ?
        cfg.color_stop[sel_idx[mscg_pkg::COLOR_SEL_W-1:0]] : '0;

    // one channel per cycle: lo + ((hi - lo) * f) >>> FRAC_BITS
    always_comb begin
        case (cmd.ch_sel)
            mscg_pkg::CH_RED: begin
                lo_ch = lo_reg[3*CW-1:2*CW];
                hi_ch = hi_reg[3*CW-1:2*CW];
            end
            mscg_pkg::CH_GREEN: begin
                lo_ch = lo_reg[2*CW-1:CW];
                hi_ch = hi_reg[2*CW-1:CW];
            end
            mscg_pkg::CH_BLUE: begin
                lo_ch = lo_reg[CW-1:0];
                hi_ch = hi_reg[CW-1:0];
            end
            default: begin
                lo_ch = '0;
                hi_ch = '0;
            end
        endcase
        diff    = $signed({1'b0, hi_ch}) - $signed({1'b0, lo_ch});
        frac_s  = $signed({1'b0, frac});
        prod_c  = PW'(diff) * PW'(frac_s);
        prod_sh = prod_c >>> FRAC_BITS;
        mix_ch  = lo_ch + prod_sh[CW-1:0];
    end

    always_comb begin
        idx_next     = idx_reg;
        rem_next     = rem_reg;
        sh_next      = sh_reg;
        quo_next     = quo_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        red_next     = red_reg;
        green_next   = green_reg;
        blue_next    = blue_reg;
        out_r_next   = out_r_reg;
        out_g_next   = out_g_reg;
        out_b_next   = out_b_reg;
        m_valid_next = m_valid_reg && !m_ready;

        if (cmd.setup) begin
            if (over) begin
                quo_next = {stops - SW'(2), CLAMP_FRAC};
            end else begin
                quo_next = '0;
                rem_next = prod_m[MW-1:SW];
                sh_next  = {prod_m[SW-1:0], {FRAC_BITS{1'b0}}};
            end
            if (idx_reg != mscg_pkg::IDX_MAX) idx_next = idx_reg + IW'(1);
        end
        if (cmd.div_step) begin
            rem_next = ge ? IW'(trial - {1'b0, d}) : trial[IW-1:0];
            quo_next = {quo_reg[QW-2:0], ge};
            sh_next  = {sh_reg[QW-2:0], 1'b0};
        end
        if (cmd.fetch_lo) lo_next = sel_color;
        if (cmd.fetch_hi) hi_next = sel_color;
        if (cmd.blend) begin
            case (cmd.ch_sel)
                mscg_pkg::CH_RED:   red_next   = mix_ch;
                mscg_pkg::CH_GREEN: green_next = mix_ch;
                default:            blue_next  = mix_ch;
            endcase
        end
        if (cmd.load_out) begin
            out_r_next   = red_reg;
            out_g_next   = green_reg;
            out_b_next   = blue_reg;
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg   <= rem_next;
        sh_reg    <= sh_next;
        quo_reg   <= quo_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        red_reg   <= red_next;
        green_reg <= green_next;
        blue_reg  <= blue_next;
        out_r_reg <= out_r_next;
        out_g_reg <= out_g_next;
        out_b_reg <= out_b_next;
    end

    assign status.over     = over;
    assign status.out_free = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_red   = out_r_reg;
    assign m_green = out_g_reg;
    assign m_blue  = out_b_reg;

endmodule

`default_nettype wire

>>> tb/multi_stop_color_gradient_checker.sv
`default_nettype none

module multi_stop_color_gradient_checker
    import mscg_pkg::*;
#(
    parameter int MAX_STOPS = 6,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wr_data,
    input  wire logic                 s_valid,
    input  wire logic                 s_ready,
    input  wire logic                 s_request,
    input  wire logic                 m_valid,
    input  wire logic                 m_ready,
    input  wire logic [CH_W-1:0]      m_red,
    input  wire logic [CH_W-1:0]      m_green,
    input  wire logic [CH_W-1:0]      m_blue,
    output int                        fail_count,
    output int                        pending_colors
);

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } rgb_t;

    // fraction used once the counter runs past the end of the ramp: 0.9
    localparam logic [63:0] CLAMP_FRAC = (64'd9 << FRAC_BITS) / 64'd10;
    localparam int          MAX_PRINTS = 40;

    logic [TOTAL_W-1:0] total_count_q;
    logic [STOP_W-1:0]  stop_count_q;
    logic [COLOR_W-1:0] stop_color [NUM_COLORS];
    logic [IDX_W-1:0]   color_index;
    rgb_t               expected_colors [$];
    rgb_t               oldest;
    int                 color_seq;
    int                 stop_sel;

    function automatic logic [CH_W-1:0] mix_channel(input logic [CH_W-1:0] lo,
                                                     input logic [CH_W-1:0] hi,
                                                     input logic [63:0] frac);
        logic [63:0] acc;
        acc = (64'(lo) * ((64'd1 << FRAC_BITS) - frac) + 64'(hi) * frac) >> FRAC_BITS;
        return acc[CH_W-1:0];
    endfunction

    // color for the current counter value and settings
    function automatic rgb_t ramp_color();
        int          nstops;
        logic [63:0] span;
        logic [63:0] pos;
        logic [63:0] seg;
        logic [63:0] frac;
        logic [COLOR_W-1:0] c_lo;
        logic [COLOR_W-1:0] c_hi;
        rgb_t        r;
        nstops = int'(stop_count_q);
        if (nstops < 2)
            nstops = 2;
        if (nstops > MAX_STOPS)
            nstops = MAX_STOPS;
        span = (total_count_q > 1) ? 64'(total_count_q) - 64'd1 : 64'(DEFAULT_STEPS);
        if (64'(color_index) > span) begin
            seg  = 64'(nstops - 2);
            frac = CLAMP_FRAC;
        end else begin
            pos  = ((64'(color_index) * 64'(nstops - 1)) << FRAC_BITS) / span;
            seg  = pos >> FRAC_BITS;
            frac = pos & ((64'd1 << FRAC_BITS) - 64'd1);
        end
        if (seg >= 64'(nstops - 1)) begin
            c_lo = stop_color[nstops - 1];
            c_hi = c_lo;
            frac = '0;
        end else begin
            c_lo = stop_color[int'(seg)];
            c_hi = stop_color[int'(seg) + 1];
        end
        r.red   = mix_channel(c_lo[2*CH_W +: CH_W], c_hi[2*CH_W +: CH_W], frac);
        r.green = mix_channel(c_lo[CH_W +: CH_W],   c_hi[CH_W +: CH_W],   frac);
        r.blue  = mix_channel(c_lo[0 +: CH_W],      c_hi[0 +: CH_W],      frac);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (fail_count < MAX_PRINTS)
            $display("ERROR @%0t: %s", $time, msg);
        fail_count++;
    endtask

    task automatic check_channel(input string name, input logic [CH_W-1:0] got,
                                 input logic [CH_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("color item %0d: %s got %02h, want %02h",
                                      color_seq, name, got, want));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            total_count_q <= '0;
            stop_count_q  <= STOP_COUNT_RESET;
            for (int k = 0; k < NUM_COLORS; k++)
                stop_color[k] <= COLOR_RESET[k];
            color_index <= '0;
            expected_colors.delete();
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == REG_TOTAL_COUNT) begin
                    total_count_q <= cfg_wr_data[TOTAL_W-1:0];
                end else if (cfg_index == REG_STOP_COUNT) begin
                    stop_count_q <= cfg_wr_data[STOP_W-1:0];
                end else if (cfg_index >= REG_COLOR_STOP_0) begin
                    stop_sel = int'(cfg_index - REG_COLOR_STOP_0);
                    if (stop_sel < NUM_COLORS)
                        stop_color[stop_sel] <= cfg_wr_data[COLOR_W-1:0];
                end
            end
            // results first, so a result cannot be matched to a request of the same edge
            if (m_valid && m_ready) begin
                if (expected_colors.size() == 0) begin
                    report_mismatch($sformatf("color item %0d arrived with none expected",
                                              color_seq));
                end else begin
                    oldest = expected_colors.pop_front();
                    check_channel("red",   m_red,   oldest.red);
                    check_channel("green", m_green, oldest.green);
                    check_channel("blue",  m_blue,  oldest.blue);
                end
                color_seq++;
            end
            if (s_valid && s_ready && s_request) begin
                expected_colors.push_back(ramp_color());
                if (color_index != IDX_MAX)
                    color_index <= color_index + 1'b1;
            end
        end
        pending_colors <= expected_colors.size();
    end

endmodule

`default_nettype wire

>>> tb/multi_stop_color_gradient_test.sv
`default_nettype none

module multi_stop_color_gradient_test;
    import mscg_pkg::*;

    localparam int FRAC_BITS       = 16;
    localparam int CYCLE_LIMIT     = 4_000_000;
    localparam int RANDOM_REQUESTS = 380;
    // drain margin after the last expected color; covers a dropped request still in flight too
    localparam int DRAIN_CYCLES    = 40;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wr_data;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_request;
    logic                 m_valid;
    logic                 m_ready;
    logic [CH_W-1:0]      m_red;
    logic [CH_W-1:0]      m_green;
    logic [CH_W-1:0]      m_blue;

    int mismatches;
    int pending_colors;
    int cycle_count    = 0;
    int send_idle_pct  = 17;
    int recv_idle_pct  = 51;
    // requests taken so far, saturating like the block's counter
    int requests_done  = 0;

    // palette that the next settings load writes to the stop registers
    logic [COLOR_W-1:0] palette [NUM_COLORS];

    multi_stop_color_gradient #(
        .MAX_STOPS(6),
        .FRAC_BITS(FRAC_BITS)
    ) DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_request  (s_request),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_red      (m_red),
        .m_green    (m_green),
        .m_blue     (m_blue)
    );

    multi_stop_color_gradient_checker #(
        .MAX_STOPS(6),
        .FRAC_BITS(FRAC_BITS)
    ) color_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_request     (s_request),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_red         (m_red),
        .m_green       (m_green),
        .m_blue        (m_blue),
        .fail_count    (mismatches),
        .pending_colors(pending_colors)
    );

    always #5 aclk = ~aclk;

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // One item through the request channel. Entered and left at a rising edge.
    // s_ready is looked at on the falling edge, where it is settled.
    task automatic send_request(input logic req);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid   <= 1'b0;
            s_request <= 1'($urandom);
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_request <= req;
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
        if (req && requests_done < int'(IDX_MAX))
            requests_done++;
    endtask

    // drop valid, let every expected color come back, then let the pipe drain
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_colors != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // writes all registers: span, stop count, then the palette
    task automatic load_settings(input logic [TOTAL_W-1:0] total,
                                 input logic [STOP_W-1:0] stops);
        logic [CFG_IDX_W-1:0] sel;
        for (int k = 0; k < int'(REG_COLOR_STOP_0) + NUM_COLORS; k++) begin
            sel = CFG_IDX_W'(k);
            cfg_wr_en <= 1'b1;
            cfg_index <= sel;
            if (sel == REG_TOTAL_COUNT)
                cfg_wr_data <= CFG_W'(total);
            else if (sel == REG_STOP_COUNT)
                cfg_wr_data <= CFG_W'(stops);
            else
                cfg_wr_data <= palette[int'(sel - REG_COLOR_STOP_0)];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        logic [TOTAL_W-1:0] span_total;
        logic               req;
        int                 random_done;
        int                 burst_len;

        random_done = 0;
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_index   <= '0;
        cfg_wr_data <= '0;
        s_valid     <= 1'b0;
        s_request   <= 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // --- directed ---
        // reset palette and span: dropped request, first stop, first step
        send_request(1'b0);
        send_request(1'b1);
        send_request(1'b1);
        wait_idle();

        // black/white alternation then green and magenta, stop count above range (acts as six),
        // span of 8: walks through segments, hits the last stop exactly,
        // then runs past the end into the clamp
        palette = '{24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h00FF00, 24'hFF00FF};
        load_settings(TOTAL_W'(9), STOP_W'(7));
        repeat (9) send_request(1'b1);
        wait_idle();

        // stop count below range acts as two; total of one means 100 steps
        load_settings(TOTAL_W'(1), STOP_W'(0));
        repeat (2) send_request(1'b1);
        wait_idle();

        load_settings(TOTAL_W'(0), STOP_W'(1));
        send_request(1'b1);
        send_request(1'b0);
        send_request(1'b1);
        wait_idle();

        // --- random phases: new settings, then a burst of requests ---
        while (random_done < RANDOM_REQUESTS) begin
            if (random_done < RANDOM_REQUESTS / 3) begin
                send_idle_pct = 17;
                recv_idle_pct = 51;
            end else if (random_done < 2 * RANDOM_REQUESTS / 3) begin
                send_idle_pct = 51;
                recv_idle_pct = 17;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            for (int k = 0; k < NUM_COLORS; k++) begin
                case ($urandom_range(7))
                    0:       palette[k] = '0;
                    1:       palette[k] = '1;
                    default: palette[k] = COLOR_W'($urandom);
                endcase
            end

            // mostly keep the counter inside the ramp so the divider does real work
            case ($urandom_range(9))
                6:       span_total = TOTAL_W'($urandom_range(1));
                7:       span_total = TOTAL_W'($urandom_range(65535));
                8:       span_total = (requests_done > 22) ?
                                      TOTAL_W'(requests_done - $urandom_range(20)) :
                                      TOTAL_W'(2);
                9:       span_total = TOTAL_W'(requests_done + 1);
                default: span_total = TOTAL_W'(requests_done + $urandom_range(2, 60));
            endcase
            load_settings(span_total, STOP_W'($urandom_range(7)));

            burst_len = $urandom_range(8, 30);
            repeat (burst_len) begin
                req = ($urandom_range(99) >= 12);
                send_request(req);
                if (req)
                    random_done++;
            end
            wait_idle();
        end

        // widest span: positions close to the start of a very long ramp
        send_idle_pct = 0;
        recv_idle_pct = 0;
        palette = '{24'hFFFFFF, 24'h000000, 24'h808080, 24'h0F0F0F, 24'hF0F0F0, 24'h123456};
        load_settings(TOTAL_W'(16'hFFFF), STOP_W'(6));
        repeat (6) send_request(1'b1);
        wait_idle();

        load_settings(TOTAL_W'(0), STOP_W'(2));
        repeat (2) send_request(1'b1);
        wait_idle();

        if (mismatches == 0 && pending_colors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
hdl/mscg_pkg.sv
hdl/mscg_cfg_regs.sv
hdl/mscg_ctrl.sv
hdl/mscg_datapath.sv
hdl/multi_stop_color_gradient.sv
tb/multi_stop_color_gradient_checker.sv
tb/multi_stop_color_gradient_test.sv
